// ----- rtl/uhcr_pkg.sv -----
// ----------------------------------------------------------------------------
// uhcr_pkg
// Shared types and constants of the ultrasonic hit counter and reporter.
// ----------------------------------------------------------------------------
package uhcr_pkg;

  // Pings per burst and the echo lanes that exist in the stream item
  localparam int PINGS         = 3;
  localparam int LANES_PRESENT = 3;
  localparam int LANES         = (PINGS < LANES_PRESENT) ? PINGS : LANES_PRESENT;
  localparam int CNT_W         = $clog2(LANES + 1);

  // Field widths
  localparam int WIDTH_W = 15;
  localparam int DIST_W  = 13;
  localparam int LAST_W  = 14;
  localparam int SUM_W   = 15;
  localparam int COUNT_W = 16;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;

  // Width to 1/16 cm: (width * 1114) >> 12
  localparam int SCALE_W     = 11;
  localparam int SCALE_SHIFT = 12;
  localparam logic [SCALE_W-1:0] SCALE_MUL = 11'd1114;
  localparam int PROD_W = WIDTH_W + SCALE_W;

  // floor(x / 3) = (x * 43691) >> 17, exact for x below 2^16
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 17;
  localparam logic [RECIP_W-1:0] RECIP3 = 16'd43691;

  // Input tdata layout: per echo lane a 16-bit slot {ok, width}
  localparam int ECHO_STRIDE = 16;
  localparam int NOW_LSB     = 48;
  localparam int LINK_BIT    = 80;
  localparam int S_TDATA_W   = 88;
  localparam int M_TDATA_W   = 32;

  // Register reset values
  localparam logic [DIST_W-1:0]  HIT_THR_RST   = 13'd320;
  localparam logic [DIST_W-1:0]  MAX_VALID_RST = 13'd6400;
  localparam logic [DIST_W-1:0]  CHANGE_RST    = 13'd8;
  localparam logic [CFG_W-1:0]   HEARTBEAT_RST = 16'd500;
  localparam logic [CFG_W-1:0]   MIN_INT_RST   = 16'd100;
  localparam logic [LAST_W-1:0]  LAST_DIST_RST = 14'h3FF0;  // minus one cm

  typedef enum logic [2:0] {
    REG_HIT_THR   = 3'd0,
    REG_MAX_VALID = 3'd1,
    REG_CHANGE    = 3'd2,
    REG_HEARTBEAT = 3'd3,
    REG_MIN_INT   = 3'd4
  } reg_idx_e;

  // One lane's finding
  typedef struct packed {
    logic              ok;
    logic [DIST_W-1:0] reading;
  } lane_res_t;

  // Stage enables of the merge unit
  typedef struct packed {
    logic sum_en;
    logic div_en;
  } merge_ctrl_t;

endpackage

// ----- rtl/uhcr_lane.sv -----
// ----------------------------------------------------------------------------
// uhcr_lane
// One echo lane: scale the pulse width to distance and qualify it.
// ----------------------------------------------------------------------------
module uhcr_lane (
  input  logic                             clk_i,
  input  logic                             load_i,
  input  logic [uhcr_pkg::WIDTH_W-1:0]     width_i,
  input  logic                             ok_i,
  input  logic [uhcr_pkg::DIST_W-1:0]      max_valid_i,
  output uhcr_pkg::lane_res_t              res_o
);
  import uhcr_pkg::*;

  logic [PROD_W-1:0]         prod;
  logic [LAST_W-1:0]         scaled;
  logic                      valid;
  lane_res_t                 res_q;

  assign prod   = PROD_W'(width_i) * PROD_W'(SCALE_MUL);
  assign scaled = prod[SCALE_SHIFT +: LAST_W];
  assign valid  = ok_i && (scaled != '0) && (scaled < {1'b0, max_valid_i});

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q.ok      <= valid;
      res_q.reading <= valid ? scaled[DIST_W-1:0] : '0;
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/uhcr_merge.sv -----
// ----------------------------------------------------------------------------
// uhcr_merge
// Merge the lanes: sum and count the valid readings, then take the mean.
// ----------------------------------------------------------------------------
module uhcr_merge (
  input  logic                         clk_i,
  input  uhcr_pkg::merge_ctrl_t        ctrl_i,
  input  uhcr_pkg::lane_res_t          lanes_i [uhcr_pkg::LANES],
  input  logic [uhcr_pkg::DIST_W-1:0]  max_valid_i,
  output logic [uhcr_pkg::DIST_W-1:0]  dist_o
);
  import uhcr_pkg::*;

  localparam int QPROD_W = SUM_W + RECIP_W;

  logic [SUM_W-1:0]   sum_d, sum_q;
  logic [CNT_W-1:0]   cnt_d, cnt_q;
  logic [QPROD_W-1:0] qprod;
  logic [DIST_W-1:0]  mean_d, mean_q;

  always_comb begin
    sum_d = '0;
    cnt_d = '0;
    for (int i = 0; i < LANES; i++) begin
      if (lanes_i[i].ok) begin
        sum_d = sum_d + SUM_W'(lanes_i[i].reading);
        cnt_d = cnt_d + CNT_W'(1);
      end
    end
  end

  assign qprod = QPROD_W'(sum_q) * QPROD_W'(RECIP3);

  // Divide by a lane count of one to three; no valid reading gives the bound
  always_comb begin
    case (cnt_q)
      CNT_W'(0): mean_d = max_valid_i;
      CNT_W'(1): mean_d = sum_q[DIST_W-1:0];
      CNT_W'(2): mean_d = sum_q[DIST_W:1];
      default:   mean_d = qprod[RECIP_SHIFT +: DIST_W];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
    if (ctrl_i.div_en) begin
      mean_q <= mean_d;
    end
  end

  assign dist_o = mean_q;

endmodule

// ----- rtl/ultrasonic_hit_counter_reporter_unit.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_hit_counter_reporter_unit
// Averages three ultrasonic echo readings per transaction, counts hits and
// decides whether a report goes out.
// ----------------------------------------------------------------------------
// Each input transaction carries three echo widths with ok flags, a ms time
// stamp and a link flag; it yields exactly one result transaction. Three echo
// lanes scale the widths to 1/16 cm side by side, a merge unit sums the valid
// readings and divides by their count (shift or reciprocal multiply), and a
// decision step updates the hit count and report state. One transaction is in
// work at a time: the lanes scale on the accepting edge, then the sum, divide
// and decide states follow in turn, the decide step writing the result into
// the output register; a new input is taken only once decide has fired, so
// transactions never overlap. A result waiting in the output register
// does not block the next input; only the decide step waits for the register
// to free up. Configuration registers may be written at any time the block is
// idle; tuser carries the reset-command kind bit. No clearing pass after reset.
// ----------------------------------------------------------------------------
module ultrasonic_hit_counter_reporter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata, low bit up: echo_width_a[14:0], echo_ok_a[15], echo_width_b[30:16],
  // echo_ok_b[31], echo_width_c[46:32], echo_ok_c[47], now_ms[79:48],
  // link_up[80], zero fill [87:81]
  input  logic [uhcr_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // tuser: kind[0]
  input  logic                              s_axis_tuser,
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata, low bit up: distance[12:0], hit_total[28:13], hit_edge[29],
  // in_range[30], report[31]
  output logic [uhcr_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [2:0]                        cfg_index_i,
  input  logic [uhcr_pkg::CFG_W-1:0]        cfg_data_i
);
  import uhcr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DEC  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [DIST_W-1:0] hit_thr_q, max_valid_q, change_q;
  logic [CFG_W-1:0]  heartbeat_q, min_int_q;

  // Item fields held for the decide step
  logic              kind_q, link_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] elapsed_q;

  // Block state
  logic [COUNT_W-1:0] hit_cnt_q, hit_cnt_d;
  logic               was_hit_q, was_hit_d;
  logic [LAST_W-1:0]  last_dist_q;
  logic [TIME_W-1:0]  last_time_q;

  // Result register
  logic                 m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;

  lane_res_t         lane_res [LANES];
  merge_ctrl_t       mctrl;
  logic [DIST_W-1:0] avg_dist;

  logic in_fire, dec_fire;

  assign s_axis_tready = state_q[0];
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // ---- Configuration -------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_thr_q   <= HIT_THR_RST;
      max_valid_q <= MAX_VALID_RST;
      change_q    <= CHANGE_RST;
      heartbeat_q <= HEARTBEAT_RST;
      min_int_q   <= MIN_INT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HIT_THR:   hit_thr_q   <= cfg_data_i[DIST_W-1:0];
        REG_MAX_VALID: max_valid_q <= cfg_data_i[DIST_W-1:0];
        REG_CHANGE:    change_q    <= cfg_data_i[DIST_W-1:0];
        REG_HEARTBEAT: heartbeat_q <= cfg_data_i;
        REG_MIN_INT:   min_int_q   <= cfg_data_i;
        default:       ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---- Echo lanes: scale on the accepting edge -----------------------------
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    uhcr_lane u_lane (
      .clk_i       (clk_i),
      .load_i      (in_fire),
      .width_i     (s_axis_tdata[g*ECHO_STRIDE +: WIDTH_W]),
      .ok_i        (s_axis_tdata[g*ECHO_STRIDE + WIDTH_W]),
      .max_valid_i (max_valid_q),
      .res_o       (lane_res[g])
    );
  end

  // ---- Merge: sum then divide ----------------------------------------------
  assign mctrl.sum_en = state_q[1];
  assign mctrl.div_en = state_q[2];

  uhcr_merge u_merge (
    .clk_i       (clk_i),
    .ctrl_i      (mctrl),
    .lanes_i     (lane_res),
    .max_valid_i (max_valid_q),
    .dist_o      (avg_dist)
  );

  // Hold the scalar fields; take elapsed time while the divide runs
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= s_axis_tuser;
      link_q <= s_axis_tdata[LINK_BIT];
      now_q  <= s_axis_tdata[NOW_LSB +: TIME_W];
    end
    if (state_q[2]) begin
      elapsed_q <= now_q - last_time_q;
    end
  end

  // ---- Decide --------------------------------------------------------------
  logic                     in_range, edge_hit, want, sent;
  logic                     chg_big, beat, gap_ok;
  logic signed [LAST_W:0]   diff;
  logic [LAST_W:0]          mag;

  assign in_range = avg_dist < hit_thr_q;
  assign diff     = $signed({2'b00, avg_dist})
                  - $signed({last_dist_q[LAST_W-1], last_dist_q});
  assign mag      = diff[LAST_W] ? (LAST_W+1)'(-diff) : diff;
  assign chg_big  = mag > {2'b00, change_q};
  assign beat     = elapsed_q > {16'h0000, heartbeat_q};
  assign gap_ok   = elapsed_q >= {16'h0000, min_int_q};

  always_comb begin
    hit_cnt_d = hit_cnt_q;
    was_hit_d = was_hit_q;
    edge_hit  = 1'b0;
    want      = 1'b0;
    if (kind_q) begin
      // reset command: clear the count, always offer a report
      hit_cnt_d = '0;
      want      = 1'b1;
    end else begin
      if (in_range && !was_hit_q) begin
        if (hit_cnt_q != '1) begin
          hit_cnt_d = hit_cnt_q + COUNT_W'(1);
        end
        was_hit_d = 1'b1;
        edge_hit  = 1'b1;
        want      = 1'b1;
      end else if (!in_range && was_hit_q) begin
        was_hit_d = 1'b0;
        want      = 1'b1;
      end
      if (chg_big || beat) begin
        want = 1'b1;
      end
    end
  end

  assign sent     = want && link_q && gap_ok;
  assign dec_fire = state_q[3] && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q   <= '0;
      was_hit_q   <= 1'b0;
      last_dist_q <= LAST_DIST_RST;
      last_time_q <= '0;
    end else if (dec_fire) begin
      hit_cnt_q <= hit_cnt_d;
      was_hit_q <= was_hit_d;
      if (sent) begin
        last_dist_q <= {1'b0, avg_dist};
        last_time_q <= now_q;
      end
    end
  end

  // ---- Sequencer -----------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire)  state_d = ST_SUM;
      ST_SUM:                state_d = ST_DIV;
      ST_DIV:                state_d = ST_DEC;
      ST_DEC:  if (dec_fire) state_d = ST_IDLE;
      default:               state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---- Output register -----------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (dec_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_fire) begin
      m_data_q <= {sent, in_range, edge_hit, hit_cnt_d, avg_dist};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ----- rtl/uhcr_checker.sv -----
// ----------------------------------------------------------------------------
// uhcr_checker
// Port-level checks of the hit counter and reporter, bound to the top level.
// ----------------------------------------------------------------------------
module uhcr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [uhcr_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
  import uhcr_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // One transaction in work: no input taken on the next edge
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // A hit edge only comes with an in-range distance
  a_edge_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[29] || m_axis_tdata[30]))
    else $error("hit edge outside range");

  // A hit edge leaves a non-zero count
  a_edge_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[29] |-> (m_axis_tdata[28:13] != '0))
    else $error("hit edge with zero count");

endmodule

bind ultrasonic_hit_counter_reporter_unit uhcr_checker u_uhcr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
